// File: rtl/lsps_pkg.sv
// Shared types, constants and width helpers for the line sensor PID steering block.
// Used by every module under rtl/; depends on nothing else.
package lsps_pkg;

  // Default parameter values.
  localparam int unsigned SENSOR_COUNT_DEF = 4;
  localparam int unsigned ADC_BITS_DEF     = 12;

  // Fixed field widths.
  localparam int unsigned DUTY_W      = 7;
  localparam int unsigned GAIN_W      = 12;
  localparam int unsigned CAL_W       = 12;
  localparam int unsigned VAL_W       = 10;
  localparam int unsigned MAP_PROD_W  = CAL_W + VAL_W;
  localparam int unsigned DUTY_Q_W    = 15;
  localparam int unsigned ERR_W       = 14;
  localparam int unsigned DIFF_W      = 15;
  localparam int unsigned STEER_W     = 16;
  localparam int unsigned PROD_W      = GAIN_W + 1 + DIFF_W;
  localparam int unsigned ACC_W       = PROD_W + 2;
  localparam int unsigned DUTY_X_W    = 18;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned WEIGHT_W    = 5;

  // Algorithm constants.
  localparam int SENSE_FULL   = 1000;
  localparam int SENSE_LIMIT  = 400;
  localparam int LOST_ERROR   = 6400;
  localparam int INTEG_LIMIT  = 7680;
  localparam int ERR_MAX      = 8191;
  localparam int ERR_MIN      = -8192;
  localparam int STEER_MAX    = 32767;
  localparam int STEER_MIN    = -32768;
  localparam int ERR_SCALE_HI = 11;  // 2560 = 2^11 + 2^9
  localparam int ERR_SCALE_LO = 9;

  // Register reset values.
  localparam logic [DUTY_W-1:0] BASE_DUTY_RST = 7'd75;
  localparam logic [DUTY_W-1:0] DUTY_MIN_RST  = 7'd65;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST  = 7'd85;
  localparam logic [GAIN_W-1:0] GAIN_P_RST    = 12'd256;
  localparam logic [GAIN_W-1:0] GAIN_I_RST    = 12'd0;
  localparam logic [GAIN_W-1:0] GAIN_D_RST    = 12'd384;
  localparam logic [CAL_W-1:0]  ADC_LOW_RST   = 12'd1700;
  localparam logic [CAL_W-1:0]  ADC_HIGH_RST  = 12'd4000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_DUTY,
    CFG_DUTY_MIN,
    CFG_DUTY_MAX,
    CFG_GAIN_P,
    CFG_GAIN_I,
    CFG_GAIN_D,
    CFG_ADC_LOW,
    CFG_ADC_HIGH
  } cfg_reg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] base_duty;
    logic [DUTY_W-1:0] duty_min;
    logic [DUTY_W-1:0] duty_max;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [CAL_W-1:0]  adc_low;
    logic [CAL_W-1:0]  adc_high;
  } lsps_cfg_t;

  // PID term selected for the shared multiplier.
  typedef enum logic [1:0] {
    PID_P,
    PID_I,
    PID_D
  } pid_term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_SETUP,
    ST_MAP_DIV,
    ST_MAP_ACC,
    ST_ERR_SETUP,
    ST_ERR_DIV,
    ST_ERR_FIN,
    ST_PID,
    ST_STEER,
    ST_OUT
  } lsps_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      map_setup;
    logic      div_step;
    logic      map_acc;
    logic      err_setup;
    logic      err_fin;
    logic      pid_mul;
    logic      pid_acc;
    pid_term_t pid_sel;
    logic      steer_calc;
    logic      out_load;
  } lsps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } lsps_status_t;

  // Quotient bits of the shared divider: covers |error| up to (n-1)*2560.
  function automatic int unsigned quot_bits(int unsigned n);
    return $clog2((n - 1) * 2560 + 1);
  endfunction

  // Bits of the unsigned sum of all sensor values.
  function automatic int unsigned sum_bits(int unsigned n);
    return $clog2(n * SENSE_FULL + 1);
  endfunction

  // Bits of the signed weighted sum.
  function automatic int unsigned wsum_bits(int unsigned n);
    return $clog2((n - 1) * n * SENSE_FULL + 1) + 1;
  endfunction

  // Input beat width, padded to whole bytes.
  function automatic int unsigned in_tdata_bits(int unsigned n, int unsigned b);
    return ((n * b + 7) / 8) * 8;
  endfunction

endpackage

// File: rtl/lsps_cfg_regs.sv
// Configuration register file for the line sensor PID steering block.
// Depends on lsps_pkg for the register indexes, reset values and the bundle type.
module lsps_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lsps_pkg::lsps_cfg_t              cfg
);

  lsps_pkg::lsps_cfg_t cfg_r;
  lsps_pkg::lsps_cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index of a write beat.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (lsps_pkg::cfg_reg_t'(cfg_index))
        lsps_pkg::CFG_BASE_DUTY: cfg_nxt.base_duty = cfg_data[lsps_pkg::DUTY_W-1:0];
        lsps_pkg::CFG_DUTY_MIN:  cfg_nxt.duty_min  = cfg_data[lsps_pkg::DUTY_W-1:0];
        lsps_pkg::CFG_DUTY_MAX:  cfg_nxt.duty_max  = cfg_data[lsps_pkg::DUTY_W-1:0];
        lsps_pkg::CFG_GAIN_P:    cfg_nxt.gain_p    = cfg_data[lsps_pkg::GAIN_W-1:0];
        lsps_pkg::CFG_GAIN_I:    cfg_nxt.gain_i    = cfg_data[lsps_pkg::GAIN_W-1:0];
        lsps_pkg::CFG_GAIN_D:    cfg_nxt.gain_d    = cfg_data[lsps_pkg::GAIN_W-1:0];
        lsps_pkg::CFG_ADC_LOW:   cfg_nxt.adc_low   = cfg_data[lsps_pkg::CAL_W-1:0];
        lsps_pkg::CFG_ADC_HIGH:  cfg_nxt.adc_high  = cfg_data[lsps_pkg::CAL_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register storage with documented reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_duty <= lsps_pkg::BASE_DUTY_RST;
      cfg_r.duty_min  <= lsps_pkg::DUTY_MIN_RST;
      cfg_r.duty_max  <= lsps_pkg::DUTY_MAX_RST;
      cfg_r.gain_p    <= lsps_pkg::GAIN_P_RST;
      cfg_r.gain_i    <= lsps_pkg::GAIN_I_RST;
      cfg_r.gain_d    <= lsps_pkg::GAIN_D_RST;
      cfg_r.adc_low   <= lsps_pkg::ADC_LOW_RST;
      cfg_r.adc_high  <= lsps_pkg::ADC_HIGH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/lsps_ctrl.sv
// Sequencing state machine for the line sensor PID steering block.
// Depends on lsps_pkg for the state, command and status types.
module lsps_ctrl #(
  parameter int unsigned SENSOR_COUNT = lsps_pkg::SENSOR_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  lsps_pkg::lsps_status_t          status,
  output lsps_pkg::lsps_cmd_t             cmd,
  output logic [$clog2(SENSOR_COUNT)-1:0] sens_idx
);

  localparam int unsigned SIDX_W = $clog2(SENSOR_COUNT);
  localparam int unsigned Q_W    = lsps_pkg::quot_bits(SENSOR_COUNT);
  localparam int unsigned STEP_W = $clog2(Q_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(Q_W - 1);
  localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(SENSOR_COUNT - 1);
  localparam logic [1:0]        PID_LAST  = 2'd3;

  lsps_pkg::lsps_state_t state_r, state_nxt;
  logic [SIDX_W-1:0] sens_idx_r, sens_idx_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        pid_r, pid_nxt;

  assign sens_idx = sens_idx_r;

  // Next state and counters.
  always_comb begin
    state_nxt    = state_r;
    sens_idx_nxt = sens_idx_r;
    step_nxt     = step_r;
    pid_nxt      = pid_r;
    case (state_r)
      lsps_pkg::ST_IDLE: begin
        sens_idx_nxt = '0;
        if (in_tvalid) begin
          state_nxt = lsps_pkg::ST_MAP_SETUP;
        end
      end
      lsps_pkg::ST_MAP_SETUP: begin
        step_nxt  = '0;
        state_nxt = lsps_pkg::ST_MAP_DIV;
      end
      lsps_pkg::ST_MAP_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = lsps_pkg::ST_MAP_ACC;
        end
      end
      lsps_pkg::ST_MAP_ACC: begin
        if (sens_idx_r == SIDX_LAST) begin
          state_nxt = lsps_pkg::ST_ERR_SETUP;
        end else begin
          sens_idx_nxt = sens_idx_r + 1'b1;
          state_nxt    = lsps_pkg::ST_MAP_SETUP;
        end
      end
      lsps_pkg::ST_ERR_SETUP: begin
        step_nxt  = '0;
        state_nxt = lsps_pkg::ST_ERR_DIV;
      end
      lsps_pkg::ST_ERR_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = lsps_pkg::ST_ERR_FIN;
        end
      end
      lsps_pkg::ST_ERR_FIN: begin
        pid_nxt   = '0;
        state_nxt = lsps_pkg::ST_PID;
      end
      lsps_pkg::ST_PID: begin
        pid_nxt = pid_r + 1'b1;
        if (pid_r == PID_LAST) begin
          state_nxt = lsps_pkg::ST_STEER;
        end
      end
      lsps_pkg::ST_STEER: begin
        state_nxt = lsps_pkg::ST_OUT;
      end
      lsps_pkg::ST_OUT: begin
        if (status.out_free) begin
          state_nxt = lsps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lsps_pkg::ST_IDLE;
      end
    endcase
  end

  // Command outputs decoded from the state.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      lsps_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      lsps_pkg::ST_MAP_SETUP: cmd.map_setup = 1'b1;
      lsps_pkg::ST_MAP_DIV:   cmd.div_step  = 1'b1;
      lsps_pkg::ST_MAP_ACC:   cmd.map_acc   = 1'b1;
      lsps_pkg::ST_ERR_SETUP: cmd.err_setup = 1'b1;
      lsps_pkg::ST_ERR_DIV:   cmd.div_step  = 1'b1;
      lsps_pkg::ST_ERR_FIN:   cmd.err_fin   = 1'b1;
      lsps_pkg::ST_PID: begin
        // Multiply term k while accumulating term k-1.
        cmd.pid_mul = (pid_r != PID_LAST);
        cmd.pid_acc = (pid_r != '0);
        case (pid_r)
          2'd0:    cmd.pid_sel = lsps_pkg::PID_P;
          2'd1:    cmd.pid_sel = lsps_pkg::PID_I;
          2'd2:    cmd.pid_sel = lsps_pkg::PID_D;
          default: cmd.pid_sel = lsps_pkg::PID_P;
        endcase
      end
      lsps_pkg::ST_STEER: cmd.steer_calc = 1'b1;
      lsps_pkg::ST_OUT:   cmd.out_load   = status.out_free;
      default:            cmd = '0;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lsps_pkg::ST_IDLE;
      sens_idx_r <= '0;
      step_r     <= '0;
      pid_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      sens_idx_r <= sens_idx_nxt;
      step_r     <= step_nxt;
      pid_r      <= pid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // An accepted beat always starts mapping at the first sensor.
  a_start_first_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == lsps_pkg::ST_MAP_SETUP && sens_idx_r == '0)
    else $error("sweep did not start at the first sensor");

  // The error division finishes after its last quotient step.
  a_err_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lsps_pkg::ST_ERR_DIV && step_r == STEP_LAST |=>
      state_r == lsps_pkg::ST_ERR_FIN)
    else $error("error division did not finish after the last step");
`endif

endmodule

// File: rtl/lsps_dp.sv
// Datapath of the line sensor PID steering block: sensor mapping, shared
// restoring divider, PID multiply-accumulate, duty clamps and output register.
// Depends on lsps_pkg for types, constants and width helpers.
module lsps_dp #(
  parameter int unsigned SENSOR_COUNT = lsps_pkg::SENSOR_COUNT_DEF,
  parameter int unsigned ADC_BITS     = lsps_pkg::ADC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [lsps_pkg::in_tdata_bits(SENSOR_COUNT, ADC_BITS)-1:0] in_tdata,
  input  lsps_pkg::lsps_cfg_t                     cfg,
  input  lsps_pkg::lsps_cmd_t                     cmd,
  input  logic [$clog2(SENSOR_COUNT)-1:0]         sens_idx,
  input  logic                                    out_tready,
  output logic                                    out_tvalid,
  output logic [lsps_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output lsps_pkg::lsps_status_t                  status
);

  localparam int unsigned Q_W    = lsps_pkg::quot_bits(SENSOR_COUNT);
  localparam int unsigned SUM_W  = lsps_pkg::sum_bits(SENSOR_COUNT);
  localparam int unsigned WSUM_W = lsps_pkg::wsum_bits(SENSOR_COUNT);
  localparam int unsigned D_W    = (SUM_W > lsps_pkg::CAL_W) ? SUM_W : lsps_pkg::CAL_W;
  localparam int unsigned R_W    = D_W + Q_W;
  localparam int unsigned RAW_W  = (ADC_BITS > lsps_pkg::CAL_W) ? ADC_BITS : lsps_pkg::CAL_W;
  localparam int unsigned EF_W   = (Q_W + 1 > lsps_pkg::ERR_W) ? Q_W + 1 : lsps_pkg::ERR_W;
  localparam int unsigned ERR_W  = lsps_pkg::ERR_W;
  localparam int unsigned DIFF_W = lsps_pkg::DIFF_W;
  localparam int unsigned ACC_W  = lsps_pkg::ACC_W;
  localparam int unsigned VAL_W  = lsps_pkg::VAL_W;
  localparam int unsigned DQ_W   = lsps_pkg::DUTY_Q_W;
  localparam int unsigned DX_W   = lsps_pkg::DUTY_X_W;
  localparam int unsigned ST_W   = lsps_pkg::STEER_W;

  localparam logic signed [EF_W-1:0]   EF_MAX     = EF_W'(lsps_pkg::ERR_MAX);
  localparam logic signed [EF_W-1:0]   EF_MIN     = EF_W'(lsps_pkg::ERR_MIN);
  localparam logic signed [ERR_W-1:0]  LOST_POS   = ERR_W'(lsps_pkg::LOST_ERROR);
  localparam logic signed [ERR_W-1:0]  LOST_NEG   = ERR_W'(-lsps_pkg::LOST_ERROR);
  localparam logic signed [DIFF_W-1:0] INTEG_POS  = DIFF_W'(lsps_pkg::INTEG_LIMIT);
  localparam logic signed [DIFF_W-1:0] INTEG_NEG  = DIFF_W'(-lsps_pkg::INTEG_LIMIT);
  localparam logic signed [ACC_W-1:0]  STEER_POS  = ACC_W'(lsps_pkg::STEER_MAX);
  localparam logic signed [ACC_W-1:0]  STEER_NEG  = ACC_W'(lsps_pkg::STEER_MIN);
  localparam logic [VAL_W-1:0]         VAL_FULL   = VAL_W'(lsps_pkg::SENSE_FULL);
  localparam logic [VAL_W-1:0]         VAL_LIMIT  = VAL_W'(lsps_pkg::SENSE_LIMIT);

  // Duty clamp, lower limit first: crossed limits give lo below lo, else hi.
  function automatic logic [DQ_W-1:0] duty_clamp(logic signed [DX_W-1:0] x,
                                                  logic [DQ_W-1:0] lo,
                                                  logic [DQ_W-1:0] hi);
    logic signed [DX_W-1:0] lo_s;
    logic signed [DX_W-1:0] hi_s;
    lo_s = $signed(DX_W'(lo));
    hi_s = $signed(DX_W'(hi));
    if (x < lo_s) begin
      return lo;
    end else if (x > hi_s) begin
      return hi;
    end
    return x[DQ_W-1:0];
  endfunction

  // Sweep and accumulator registers.
  logic [SENSOR_COUNT-1:0][ADC_BITS-1:0] sample_r;
  logic signed [WSUM_W-1:0] wsum_r;
  logic [SUM_W-1:0]         sum_r;
  logic                     seen_r;

  // Shared divider registers.
  logic [R_W-1:0]   rem_r;
  logic [R_W-1:0]   dsh_r;
  logic [Q_W-1:0]   quo_r;
  logic             direct_r;
  logic [VAL_W-1:0] dval_r;
  logic             neg_r;

  // Controller state and PID registers.
  logic signed [ERR_W-1:0]                last_err_r;
  logic signed [ERR_W-1:0]                integ_r;
  logic signed [DIFF_W-1:0]               diff_r;
  logic signed [lsps_pkg::PROD_W-1:0]     prod_r;
  logic signed [ACC_W-1:0]                acc_r;
  logic signed [ST_W-1:0]                 steer_r;

  // Output register.
  logic                              out_valid_r;
  logic [lsps_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                              out_free;

  // Sensor mapping setup.
  logic [RAW_W-1:0]                  raw_x;
  logic [RAW_W-1:0]                  low_x;
  logic [RAW_W-1:0]                  diff_x;
  logic [lsps_pkg::CAL_W-1:0]        span;
  logic [lsps_pkg::MAP_PROD_W-1:0]   map_prod;
  logic                              map_direct;
  logic [VAL_W-1:0]                  map_dval;

  assign raw_x    = RAW_W'(sample_r[sens_idx]);
  assign low_x    = RAW_W'(cfg.adc_low);
  assign diff_x   = raw_x - low_x;
  assign span     = cfg.adc_high - cfg.adc_low;
  assign map_prod = lsps_pkg::MAP_PROD_W'(diff_x[lsps_pkg::CAL_W-1:0])
                  * lsps_pkg::MAP_PROD_W'(lsps_pkg::SENSE_FULL);

  // Readings at or below the low mark, an empty range, or at least a full span
  // are settled without the divider.
  always_comb begin
    map_direct = 1'b1;
    map_dval   = VAL_FULL;
    if (raw_x <= low_x) begin
      map_dval = '0;
    end else if (cfg.adc_high <= cfg.adc_low) begin
      map_dval = VAL_FULL;
    end else if (diff_x >= RAW_W'(span)) begin
      map_dval = VAL_FULL;
    end else begin
      map_direct = 1'b0;
    end
  end

  // Sensor value and its weight for the accumulate step.
  logic [VAL_W-1:0]                          sens_val;
  logic signed [lsps_pkg::WEIGHT_W-1:0]      weight;
  logic signed [lsps_pkg::WEIGHT_W+VAL_W:0]  wprod;

  assign sens_val = direct_r ? dval_r : quo_r[VAL_W-1:0];
  assign weight   = lsps_pkg::WEIGHT_W'(SENSOR_COUNT - 1)
                  - (lsps_pkg::WEIGHT_W'(sens_idx) << 1);
  assign wprod    = weight * $signed({1'b0, sens_val});

  // Error dividend: |wsum| * 2560 as two shifted terms.
  logic [WSUM_W-1:0] wsum_mag;
  logic [R_W-1:0]    err_dividend;

  assign wsum_mag     = (wsum_r < 0) ? WSUM_W'(-wsum_r) : WSUM_W'(wsum_r);
  assign err_dividend = (R_W'(wsum_mag) << lsps_pkg::ERR_SCALE_HI)
                      + (R_W'(wsum_mag) << lsps_pkg::ERR_SCALE_LO);

  // One restoring step of the shared divider.
  logic div_ge;
  assign div_ge = (rem_r >= dsh_r);

  // Error finish: sign, saturate, or hold a lost-line error; clamp the integral.
  logic signed [EF_W-1:0]   err_full;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [DIFF_W-1:0] integ_sum;
  logic signed [ERR_W-1:0]  integ_nxt;

  always_comb begin
    err_full = neg_r ? -$signed(EF_W'(quo_r)) : $signed(EF_W'(quo_r));
    if (!seen_r) begin
      err_nxt = (last_err_r > 0) ? LOST_POS : LOST_NEG;
    end else if (err_full > EF_MAX) begin
      err_nxt = ERR_W'(EF_MAX);
    end else if (err_full < EF_MIN) begin
      err_nxt = ERR_W'(EF_MIN);
    end else begin
      err_nxt = ERR_W'(err_full);
    end
    integ_sum = DIFF_W'(integ_r) + DIFF_W'(err_nxt);
    if (integ_sum > INTEG_POS) begin
      integ_nxt = ERR_W'(INTEG_POS);
    end else if (integ_sum < INTEG_NEG) begin
      integ_nxt = ERR_W'(INTEG_NEG);
    end else begin
      integ_nxt = ERR_W'(integ_sum);
    end
  end

  // Operand and gain for the shared PID multiplier.
  logic signed [DIFF_W-1:0]       pid_op;
  logic [lsps_pkg::GAIN_W-1:0]    pid_gain;

  always_comb begin
    case (cmd.pid_sel)
      lsps_pkg::PID_P: begin
        pid_op   = DIFF_W'(last_err_r);
        pid_gain = cfg.gain_p;
      end
      lsps_pkg::PID_I: begin
        pid_op   = DIFF_W'(integ_r);
        pid_gain = cfg.gain_i;
      end
      lsps_pkg::PID_D: begin
        pid_op   = diff_r;
        pid_gain = cfg.gain_d;
      end
      default: begin
        pid_op   = '0;
        pid_gain = '0;
      end
    endcase
  end

  // Floor division by 256 and saturation of the correction.
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [ST_W-1:0]  steer_nxt;

  always_comb begin
    acc_sh = acc_r >>> 8;
    if (acc_sh > STEER_POS) begin
      steer_nxt = ST_W'(STEER_POS);
    end else if (acc_sh < STEER_NEG) begin
      steer_nxt = ST_W'(STEER_NEG);
    end else begin
      steer_nxt = ST_W'(acc_sh);
    end
  end

  // Motor duties around the base duty.
  logic signed [DX_W-1:0] base_x;
  logic [DQ_W-1:0]        lo_q;
  logic [DQ_W-1:0]        hi_q;
  logic [DQ_W-1:0]        left_duty;
  logic [DQ_W-1:0]        right_duty;

  assign base_x     = $signed(DX_W'({cfg.base_duty, 8'd0}));
  assign lo_q       = DQ_W'({cfg.duty_min, 8'd0});
  assign hi_q       = DQ_W'({cfg.duty_max, 8'd0});
  assign left_duty  = duty_clamp(base_x - DX_W'(steer_r), lo_q, hi_q);
  assign right_duty = duty_clamp(base_x + DX_W'(steer_r), lo_q, hi_q);

  assign out_free        = !out_valid_r || out_tready;
  assign status.out_free = out_free;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_tdata[SENSOR_COUNT*ADC_BITS-1:0];
      wsum_r   <= '0;
      sum_r    <= '0;
      seen_r   <= 1'b0;
    end
    if (cmd.map_setup) begin
      rem_r    <= R_W'(map_prod);
      dsh_r    <= R_W'(span) << (Q_W - 1);
      quo_r    <= '0;
      direct_r <= map_direct;
      dval_r   <= map_dval;
    end
    if (cmd.err_setup) begin
      rem_r <= err_dividend;
      dsh_r <= R_W'(sum_r) << (Q_W - 1);
      quo_r <= '0;
      neg_r <= (wsum_r < 0);
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[Q_W-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.map_acc) begin
      wsum_r <= wsum_r + WSUM_W'(wprod);
      sum_r  <= sum_r + SUM_W'(sens_val);
      if (sens_val > VAL_LIMIT) begin
        seen_r <= 1'b1;
      end
    end
    if (cmd.err_fin) begin
      diff_r <= DIFF_W'(err_nxt) - DIFF_W'(last_err_r);
      acc_r  <= '0;
    end
    if (cmd.pid_mul) begin
      prod_r <= $signed({1'b0, pid_gain}) * pid_op;
    end
    if (cmd.pid_acc) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.steer_calc) begin
      steer_r <= steer_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= {4'd0, steer_r, last_err_r, right_duty, left_duty};
    end
  end

  // Loop state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r  <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.err_fin) begin
        last_err_r <= err_nxt;
        integ_r    <= integ_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // The integral never leaves its clamp.
  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r <= ERR_W'(INTEG_POS) && integ_r >= ERR_W'(INTEG_NEG))
    else $error("integral outside its limit");

  // A found line always leaves a nonzero divisor for the error division.
  a_err_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err_fin && seen_r |-> sum_r != '0)
    else $error("error division with zero sensor sum");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overwritten");
`endif

endmodule

// File: rtl/line_sensor_pid_steering.sv
// Top level of the line sensor PID steering block.
// Depends on lsps_pkg, lsps_cfg_regs, lsps_ctrl and lsps_dp.
//
//   channel | direction | handshake              | payload
//   in_     | sink      | in_tvalid / in_tready   | in_tdata: one raw reading per sensor
//   out_    | source    | out_tvalid / out_tready | out_tdata: duties, error, steering
//   cfg_    | sink      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each beat runs a mapping division per sensor, then the error division, the
// PID terms, the steering step and the output load before the next accept.
// The shared restoring divider yields one quotient bit per cycle.
// Reset is synchronous on rst_n low; it restores register defaults and clears
// the stored error and integral. A result waits in the output register while
// the next beat is taken and computed; only the final load waits on out_tready.
module line_sensor_pid_steering #(
  parameter int unsigned SENSOR_COUNT = lsps_pkg::SENSOR_COUNT_DEF,
  parameter int unsigned ADC_BITS     = lsps_pkg::ADC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input beat.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: raw_far_left, raw_mid_left, raw_mid_right, raw_far_right,
  // each ADC_BITS wide, zero padding to whole bytes.
  input  logic [lsps_pkg::in_tdata_bits(SENSOR_COUNT, ADC_BITS)-1:0] in_tdata,
  // Result beat.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: left_duty[14:0], right_duty[29:15], line_error[43:30],
  // steer_amount[59:44], zero padding [63:60].
  output logic [lsps_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // Configuration writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  lsps_pkg::lsps_cfg_t    cfg;
  lsps_pkg::lsps_cmd_t    cmd;
  lsps_pkg::lsps_status_t status;
  logic [$clog2(SENSOR_COUNT)-1:0] sens_idx;

  lsps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsps_ctrl #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .sens_idx  (sens_idx)
  );

  lsps_dp #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .ADC_BITS     (ADC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg        (cfg),
    .cmd        (cmd),
    .sens_idx   (sens_idx),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .status     (status)
  );

endmodule
